// File: hw/rtl/rcpa_pkg.sv
package rcpa_pkg;

  // Fixed field widths of the request and result channels.
  localparam int PAGE_W      = 15;
  localparam int COUNT_OUT_W = 8;
  localparam int FIRST_W     = 15;
  localparam int LIMIT_W     = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_PAGES  = 32768;
  localparam int DEF_COUNT_BITS = 8;

  // Depth of the small request and result queues; must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [FIRST_W-1:0] FIRST_RESET = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;

  // Configuration register indexes.
  localparam logic CFG_FIRST_USABLE = 1'b0;
  localparam logic CFG_PAGE_LIMIT   = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC     = 2'd0,
    ACT_FREE      = 2'd1,
    ACT_ADD_REF   = 2'd2,
    ACT_DEC_CHECK = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_PAGE  = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    action_e             action;
    logic [PAGE_W-1:0]   page;
    logic                bad;
  } item_t;

  // One result as it waits in the result queue.
  typedef struct packed {
    status_e                status;
    logic [PAGE_W-1:0]      alloc_page;
    logic                   copy_needed;
    logic                   page_released;
    logic [COUNT_OUT_W-1:0] count_after;
  } result_t;

  // Status of the back end, seen by the front end and the top level.
  typedef struct packed {
    logic clearing;
    logic issue;
    logic done;
  } back_stat_t;

endpackage

// File: hw/rtl/rcpa_ram.sv
module rcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rcpa_fifo.sv
module rcpa_fifo
  import rcpa_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push_ok;
  logic             pop_ok;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(push_ok) - CNT_W'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/rcpa_front.sv
module rcpa_front
  import rcpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         action_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_index_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               clearing_i,
  output item_t              item_o,
  output logic               item_valid_o,
  input  logic               item_take_i
);

  logic [FIRST_W-1:0] first_q, first_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic               q_full;
  logic               q_empty;
  logic               accept;
  logic               page_high;
  logic               free_outside;
  item_t              item_in;
  logic [$bits(item_t)-1:0] q_rdata;

  // Configuration registers; the user must write only while idle (unchecked).
  always_comb begin
    first_d = first_q;
    limit_d = limit_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST_USABLE: first_d = cfg_wdata_i[FIRST_W-1:0];
        CFG_PAGE_LIMIT:   limit_d = cfg_wdata_i;
        default:          first_d = first_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= FIRST_RESET;
      limit_q <= LIMIT_RESET;
    end else begin
      first_q <= first_d;
      limit_q <= limit_d;
    end
  end

  // Classify the request: non-alloc requests for pages beyond the count store,
  // and frees outside the usable window, are rejected later, touching no state.
  assign page_high    = (32'(page_i) >= 32'(NUM_PAGES));
  assign free_outside = (page_i < first_q) || ({1'b0, page_i} >= limit_q);

  always_comb begin
    item_in.action = action_e'(action_i);
    item_in.page   = page_i;
    item_in.bad    = (action_e'(action_i) != ACT_ALLOC) &&
                     (page_high || ((action_e'(action_i) == ACT_FREE) && free_outside));
  end

  // Requests are held off while the queue is full or the count store clears.
  assign full_o = q_full || clearing_i;
  assign accept = push_i && !full_o;

  rcpa_fifo #(
    .WIDTH ($bits(item_t))
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (item_in),
    .full_o  (q_full),
    .pop_i   (item_take_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign item_o       = item_t'(q_rdata);
  assign item_valid_o = !q_empty;

endmodule

// File: hw/rtl/rcpa_back.sv
module rcpa_back
  import rcpa_pkg::*;
#(
  parameter int NUM_PAGES  = DEF_NUM_PAGES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       item_valid_i,
  output logic       item_take_o,
  output result_t    result_o,
  output logic       empty_o,
  input  logic       pop_i,
  output back_stat_t stat_o
);

  localparam int AW  = $clog2(NUM_PAGES);
  localparam int FCW = $clog2(NUM_PAGES + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [AW-1:0]         CLR_LAST = AW'(NUM_PAGES - 1);

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  logic [FCW-1:0]        free_cnt_q, free_cnt_d;
  item_t                 cur_q, cur_d;

  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  stk_we;
  logic [PAGE_W-1:0]     stk_rdata;

  logic                  issue;
  logic                  res_push;
  result_t               res;
  logic                  out_full;
  logic [$bits(result_t)-1:0] out_rdata;

  // Low bits of a count as reported on the result channel.
  function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [COUNT_BITS-1:0] c);
    return COUNT_OUT_W'(16'(c));
  endfunction

  // Reference counts, one per page.
  rcpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (AW'(item_i.page)),
    .rdata_o (cnt_rdata)
  );

  // Free page stack; the top entry is always read for a pending alloc.
  rcpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (AW'(free_cnt_q)),
    .wdata_i (cur_q.page),
    .raddr_i (AW'(free_cnt_q - FCW'(1))),
    .rdata_o (stk_rdata)
  );

  assign cnt_dec = cnt_rdata - CNT_ONE;
  assign cnt_inc = cnt_rdata + CNT_ONE;

  // A request starts only when its result is sure to find a queue slot.
  assign issue = (state_q == ST_IDLE) && item_valid_i && !out_full;

  // Sequencer: clear pass, then a read in the idle state and the update in the cycle after it.
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    free_cnt_d  = free_cnt_q;
    cur_d       = cur_q;
    item_take_o = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = AW'(cur_q.page);
    cnt_wdata   = '0;
    stk_we      = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    res.status  = STAT_OK;

    case (state_q)
      ST_CLEAR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (issue) begin
          item_take_o = 1'b1;
          cur_d       = item_i;
          state_d     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_push = 1'b1;
        state_d  = ST_IDLE;
        if (cur_q.action == ACT_ALLOC) begin
          if (free_cnt_q == '0) begin
            res.status = STAT_NO_PAGE;
          end else begin
            free_cnt_d      = free_cnt_q - FCW'(1);
            cnt_we          = 1'b1;
            cnt_waddr       = AW'(stk_rdata);
            cnt_wdata       = CNT_ONE;
            res.alloc_page  = stk_rdata;
            res.count_after = count_out(CNT_ONE);
          end
        end else if (cur_q.bad) begin
          res.status = STAT_RANGE;
        end else begin
          case (cur_q.action)
            ACT_FREE: begin
              cnt_we = 1'b1;
              if (cnt_rdata > CNT_ONE) begin
                cnt_wdata       = cnt_dec;
                res.count_after = count_out(cnt_dec);
              end else if (free_cnt_q == FCW'(NUM_PAGES)) begin
                // Stack full: the count still drops to zero.
                res.status = STAT_OVERFLOW;
              end else begin
                stk_we            = 1'b1;
                free_cnt_d        = free_cnt_q + FCW'(1);
                res.page_released = 1'b1;
              end
            end
            ACT_ADD_REF: begin
              cnt_we    = 1'b1;
              cnt_wdata = (cnt_rdata < CNT_MAX) ? cnt_inc : cnt_rdata;
              res.count_after = count_out(cnt_wdata);
            end
            ACT_DEC_CHECK: begin
              if (cnt_rdata > CNT_ONE) begin
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_dec;
                res.copy_needed = 1'b1;
                res.count_after = count_out(cnt_dec);
              end else begin
                res.count_after = count_out(cnt_rdata);
              end
            end
            default: begin
              res.status = STAT_OK;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      free_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      free_cnt_q <= free_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Result queue toward the consumer.
  rcpa_fifo #(
    .WIDTH ($bits(result_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (out_rdata),
    .empty_o (empty_o)
  );

  assign result_o = result_t'(out_rdata);

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.issue    = issue;
  assign stat_o.done     = res_push;

endmodule

// File: hw/rtl/refcounted_page_allocator.sv
// Reference-counted page allocator with a free page stack.
//
// Requests enter through a queue-style port: a request is taken at a clock
// edge where push is high and full is low. Results leave the same way: while
// empty is low the oldest result sits on the result ports, and it is taken
// at an edge where pop is high. Every request gives exactly one result.
// Configuration writes (first usable page, page limit) go through the cfg
// channel, which is always ready; write them only while no request is open.
//
// A request waits in a short queue; the back end reads the count memory and
// the stack top in its idle state and writes them back in its execute
// state. A new request starts only once the last is written back, due to
// that read-modify-write on the count memory, whose read data is
// registered. With nothing waiting ahead, a request's result shows on the
// ports after it passes the request queue, back end and result queue.
// After reset the count memory is cleared, one entry a cycle, over all
// NUM_PAGES entries; full stays high during that pass. If the consumer
// stops popping, the result queue fills, the back end stops, and full
// rises once the request queue fills as well.
module refcounted_page_allocator
  import rcpa_pkg::*;
#(
  parameter int NUM_PAGES  = DEF_NUM_PAGES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             action_i,
  input  logic [PAGE_W-1:0]      page_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [LIMIT_W-1:0]     cfg_wdata_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             status_o,
  output logic [PAGE_W-1:0]      alloc_page_o,
  output logic                   copy_needed_o,
  output logic                   page_released_o,
  output logic [COUNT_OUT_W-1:0] count_after_o
);

  item_t      item;
  logic       item_valid;
  logic       item_take;
  result_t    result;
  back_stat_t bk_stat;

  assign cfg_ready_o = 1'b1;

  rcpa_front #(
    .NUM_PAGES (NUM_PAGES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .page_i       (page_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .clearing_i   (bk_stat.clearing),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  rcpa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .result_o     (result),
    .empty_o      (empty),
    .pop_i        (pop),
    .stat_o       (bk_stat)
  );

  assign status_o        = result.status;
  assign alloc_page_o    = result.alloc_page;
  assign copy_needed_o   = result.copy_needed;
  assign page_released_o = result.page_released;
  assign count_after_o   = result.count_after;

`ifndef SYNTHESIS
  // A started request finishes in the very next cycle.
  a_issue_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.issue |=> bk_stat.done)
    else $error("request started but no result produced");

  // A released page is always a clean success.
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && page_released_o) |-> (status_o == STAT_OK) && !copy_needed_o)
    else $error("page released with bad status");

  // An alloc that found no page hands out nothing.
  a_no_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == STAT_NO_PAGE)) |-> (alloc_page_o == '0) && (count_after_o == '0))
    else $error("failed alloc reports a page or count");
`endif

endmodule
